### design/spab_pkg.sv
`timescale 1ns / 1ps

package spab_pkg;

  // Field and register widths
  localparam int SpeedW   = 16;
  localparam int GainW    = 32;
  localparam int DriveW   = 16;
  localparam int CfgIdxW  = 2;

  // Internal arithmetic widths
  localparam int ErrW     = SpeedW + 1;      // target - measured
  localparam int DiffW    = ErrW + 1;        // err - previous err
  localparam int SumW     = 48;              // saturating error sum
  localparam int HalfW    = SumW / 2;        // split of |sum| for the I product
  localparam int PW       = GainW + 1 + ErrW;
  localparam int DW       = GainW + 1 + DiffW;
  localparam int PdW      = DW + 1;
  localparam int HalfProdW = HalfW + GainW;
  localparam int ICapW    = 54;              // capped |I| up to 2^53
  localparam int ITermW   = ICapW + 1;
  localparam int TotW     = ITermW + 1;
  localparam int ClampW   = 34;              // clamped total, +/- 2^32
  localparam int MagW     = ClampW - 1;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  // High partial product limit: above this the I term is capped outright
  localparam logic [HalfProdW-1:0] HiLimit = HalfProdW'(1) << (ICapW - 1 - HalfW);
  localparam logic [ICapW-1:0]     ICap    = ICapW'(1) << (ICapW - 1);

  localparam logic signed [TotW-1:0]   OneTot   = TotW'(1) << 32;
  localparam logic signed [ClampW-1:0] OneClamp = ClampW'(1) << 32;
  localparam logic [MagW-1:0]          RoundHalf = MagW'(1) << 16;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegGainP = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGainI = 2'd1;
  localparam logic [CfgIdxW-1:0] RegGainD = 2'd2;

  localparam logic [GainW-1:0] GainPReset = 32'd1677722;
  localparam logic [GainW-1:0] GainIReset = 32'd235;
  localparam logic [GainW-1:0] GainDReset = 32'd5872026;

  typedef struct packed {
    logic [GainW-1:0] p;
    logic [GainW-1:0] i;
    logic [GainW-1:0] d;
  } gains_t;

  // After the error stage
  typedef struct packed {
    logic signed [ErrW-1:0]  err;
    logic signed [DiffW-1:0] diff;
    logic signed [SumW-1:0]  sum;
  } err_stage_t;

  // After the P/D product stage
  typedef struct packed {
    logic signed [PW-1:0] p;
    logic signed [DW-1:0] d;
    logic [HalfW-1:0]     hi;
    logic [HalfW-1:0]     lo;
    logic                 neg;
  } prod_stage_t;

  // After the I partial product stage
  typedef struct packed {
    logic signed [PdW-1:0] pd;
    logic [HalfProdW-1:0]  ihi;
    logic [HalfProdW-1:0]  ilo;
    logic                  neg;
  } term_stage_t;

endpackage

### design/speed_pid_accel_brake.sv
`timescale 1ns / 1ps

// PID speed controller with throttle/brake split. Each request on s_axis is one
// control tick carrying target and measured speed (signed Q8.8 m/s); each tick
// yields exactly one result on m_axis with accel_drive and brake_drive in Q1.15
// (32768 = full), at most one of them nonzero. Ticks may arrive every cycle: the
// error sum and previous error are updated in the cycle a request is accepted,
// and the result becomes valid on m_axis after passing six registers (error,
// P/D product, I partial product, I cap, sum/clamp, drive register), the first
// of which loads on acceptance. Throughput is one tick per clock while m_axis
// does not stall; latency grows only while it stalls. The error sum saturates
// at 48 bits. Gains are written through cfg_we/cfg_index/cfg_data (0: kp,
// 1: ki*dt, 2: kd/dt, unsigned Q8.24); the user must write them only while no
// tick is in flight, which the block does not enforce; other indexes are ignored.
module speed_pid_accel_brake (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [2*spab_pkg::SpeedW-1:0] s_axis_tdata,  // target_speed, measured_speed
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [2*spab_pkg::DriveW-1:0] m_axis_tdata,  // accel_drive, brake_drive
  input  logic                          cfg_we,
  input  logic [spab_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [spab_pkg::GainW-1:0]    cfg_data
);
  import spab_pkg::*;

  gains_t      gains;
  err_stage_t  err_stage;
  term_stage_t term_stage;
  logic        err_valid;
  logic        err_ready;
  logic        term_valid;
  logic        term_ready;

  // gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gains.p <= GainPReset;
      gains.i <= GainIReset;
      gains.d <= GainDReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegGainP: gains.p <= cfg_data;
        RegGainI: gains.i <= cfg_data;
        RegGainD: gains.d <= cfg_data;
        default:  ;
      endcase
    end
  end

  spab_error u_error (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .out_valid (err_valid),
    .out_ready (err_ready),
    .out_stage (err_stage)
  );

  spab_terms u_terms (
    .clk       (clk),
    .rst       (rst),
    .gains     (gains),
    .in_valid  (err_valid),
    .in_ready  (err_ready),
    .in_stage  (err_stage),
    .out_valid (term_valid),
    .out_ready (term_ready),
    .out_stage (term_stage)
  );

  spab_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (term_valid),
    .in_ready  (term_ready),
    .in_stage  (term_stage),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

### design/spab_error.sv
`timescale 1ns / 1ps

module spab_error (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2*spab_pkg::SpeedW-1:0] in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output spab_pkg::err_stage_t      out_stage
);
  import spab_pkg::*;

  logic signed [SpeedW-1:0] target;
  logic signed [SpeedW-1:0] measured;
  logic signed [ErrW-1:0]   err;
  logic signed [DiffW-1:0]  diff;
  logic signed [SumW:0]     sum_wide;
  logic signed [SumW-1:0]   error_sum_next;
  logic signed [SumW-1:0]   error_sum;
  logic signed [ErrW-1:0]   previous_error;
  logic                     accept;

  assign target   = in_data[SpeedW-1:0];
  assign measured = in_data[2*SpeedW-1:SpeedW];

  // error, difference and saturating sum
  always_comb begin
    err      = {target[SpeedW-1], target} - {measured[SpeedW-1], measured};
    diff     = {err[ErrW-1], err} - {previous_error[ErrW-1], previous_error};
    sum_wide = {error_sum[SumW-1], error_sum} + {{(SumW+1-ErrW){err[ErrW-1]}}, err};
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      error_sum_next = sum_wide[SumW] ? SumMin : SumMax;
    end else begin
      error_sum_next = sum_wide[SumW-1:0];
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // controller state and stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      error_sum      <= '0;
      previous_error <= '0;
    end else begin
      if (in_ready) out_valid <= in_valid;
      if (accept) begin
        error_sum      <= error_sum_next;
        previous_error <= err;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_stage.err  <= err;
      out_stage.diff <= diff;
      out_stage.sum  <= error_sum_next;
    end
  end

endmodule

### design/spab_terms.sv
`timescale 1ns / 1ps

module spab_terms (
  input  logic                  clk,
  input  logic                  rst,
  input  spab_pkg::gains_t      gains,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  spab_pkg::err_stage_t  in_stage,
  output logic                  out_valid,
  input  logic                  out_ready,
  output spab_pkg::term_stage_t out_stage
);
  import spab_pkg::*;

  prod_stage_t             s2;
  logic                    v2;
  logic                    r2;
  logic signed [PW-1:0]    p;
  logic signed [DW-1:0]    d;
  logic [SumW-1:0]         mag;
  logic signed [PdW-1:0]   pd;
  logic [HalfProdW-1:0]    ihi;
  logic [HalfProdW-1:0]    ilo;

  assign r2       = !out_valid || out_ready;
  assign in_ready = !v2 || r2;

  // P and D products, magnitude of the error sum
  always_comb begin
    p   = $signed({1'b0, gains.p}) * in_stage.err;
    d   = $signed({1'b0, gains.d}) * in_stage.diff;
    mag = in_stage.sum[SumW-1] ? SumW'(-in_stage.sum) : SumW'(in_stage.sum);
  end

  // I partial products on the two halves of |sum|, P + D
  always_comb begin
    ihi = s2.hi * gains.i;
    ilo = s2.lo * gains.i;
    pd  = {s2.d[DW-1], s2.d} + PdW'(s2.p);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) v2 <= in_valid;
      if (r2) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s2.p   <= p;
      s2.d   <= d;
      s2.hi  <= mag[SumW-1:HalfW];
      s2.lo  <= mag[HalfW-1:0];
      s2.neg <= in_stage.sum[SumW-1];
    end
    if (v2 && r2) begin
      out_stage.pd  <= pd;
      out_stage.ihi <= ihi;
      out_stage.ilo <= ilo;
      out_stage.neg <= s2.neg;
    end
  end

endmodule

### design/spab_mix.sv
`timescale 1ns / 1ps

module spab_mix (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  spab_pkg::term_stage_t       in_stage,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2*spab_pkg::DriveW-1:0] out_data
);
  import spab_pkg::*;

  logic                      v4;
  logic                      v5;
  logic                      r4;
  logic                      r5;
  logic                      ro;
  logic signed [PdW-1:0]     pd4;
  logic signed [ITermW-1:0]  iterm;
  logic signed [ClampW-1:0]  clamped;
  logic [ICapW+3:0]          ifull;
  logic [ICapW-1:0]          icap;
  logic signed [ITermW-1:0]  iterm_next;
  logic signed [TotW-1:0]    total;
  logic signed [ClampW-1:0]  clamped_next;
  logic [MagW-1:0]           mag;
  logic [MagW-1:0]           rounded;
  logic [DriveW-1:0]         drive;

  assign ro       = !out_valid || out_ready;
  assign r5       = !v5 || ro;
  assign r4       = !v4 || r5;
  assign in_ready = r4;

  // recombine and cap the I term
  always_comb begin
    ifull = {in_stage.ihi[ICapW+3-HalfW:0], {HalfW{1'b0}}} + (ICapW+4)'(in_stage.ilo);
    if (in_stage.ihi > HiLimit || ifull > (ICapW+4)'(ICap)) begin
      icap = ICap;
    end else begin
      icap = ifull[ICapW-1:0];
    end
    iterm_next = in_stage.neg ? -$signed({1'b0, icap}) : $signed({1'b0, icap});
  end

  // P + I + D, clamped to +/- 1.0
  always_comb begin
    total = TotW'(pd4) + TotW'(iterm);
    if (total > OneTot) begin
      clamped_next = OneClamp;
    end else if (total < -OneTot) begin
      clamped_next = -OneClamp;
    end else begin
      clamped_next = total[ClampW-1:0];
    end
  end

  // magnitude to Q1.15, rounding half up
  always_comb begin
    mag     = clamped[ClampW-1] ? MagW'(-clamped) : MagW'(clamped);
    rounded = mag + RoundHalf;
    drive   = rounded[MagW-1:MagW-DriveW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r4) v4 <= in_valid;
      if (r5) v5 <= v4;
      if (ro) out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && r4) begin
      pd4   <= in_stage.pd;
      iterm <= iterm_next;
    end
    if (v4 && r5) clamped <= clamped_next;
    if (v5 && ro) begin
      // brake in the upper half, accel in the lower
      if (clamped[ClampW-1]) begin
        out_data <= {drive, {DriveW{1'b0}}};
      end else begin
        out_data <= {{DriveW{1'b0}}, drive};
      end
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import spab_pkg::*;

  localparam int CycleLimit = 100000;
  localparam int PipeDepth  = 6;
  localparam int SegItems   = 210;
  localparam int NumSegs    = 6;
  localparam int NumRows    = 31;

  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;  // no register behind this index

  localparam longint SumTop    = (longint'(1) <<< 47) - 1;
  localparam longint SumBottom = -(longint'(1) <<< 47);
  localparam longint FullScale = longint'(1) <<< 32;
  localparam longint HalfLsb   = longint'(1) <<< 16;
  localparam logic [79:0] ITermCap = 80'd1 << 53;

  localparam logic signed [SpeedW-1:0] SpeedTop    = 16'sh7fff;
  localparam logic signed [SpeedW-1:0] SpeedBottom = 16'sh8000;

  typedef struct packed {
    logic [DriveW-1:0] accel;
    logic [DriveW-1:0] brake;
  } drive_t;

  typedef enum logic { RowTick, RowGain } row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CfgIdxW-1:0]       idx;
    logic [GainW-1:0]         value;
    logic signed [SpeedW-1:0] tgt;
    logic signed [SpeedW-1:0] meas;
    logic                     known;
    logic [DriveW-1:0]        accel;
    logic [DriveW-1:0]        brake;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [2*SpeedW-1:0]   s_axis_tdata = '0;  // target_speed, measured_speed
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [2*DriveW-1:0]   m_axis_tdata;       // accel_drive, brake_drive
  logic                  cfg_we = 1'b0;
  logic [CfgIdxW-1:0]    cfg_index = '0;
  logic [GainW-1:0]      cfg_data = '0;

  // Controller state as the checker sees it
  logic [GainW-1:0] kp = GainPReset;
  logic [GainW-1:0] ki = GainIReset;
  logic [GainW-1:0] kd = GainDReset;
  longint           err_sum = 0;
  int               last_err = 0;

  drive_t drive_q[$];
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     fail_count = 0;
  int     cycle_count = 0;

  // Directed ticks and gain writes; expected drives given only where obvious
  row_t plan [NumRows] = '{
    // reset gains: zero error, full-scale errors both ways, derivative kick
    '{RowTick, RegGainP, 32'd0, 16'sd0, 16'sd0, 1'b1, 16'd0, 16'd0},
    '{RowTick, RegGainP, 32'd0, SpeedTop, SpeedBottom, 1'b1, 16'd32768, 16'd0},
    '{RowTick, RegGainP, 32'd0, SpeedBottom, SpeedTop, 1'b1, 16'd0, 16'd32768},
    '{RowTick, RegGainP, 32'd0, 16'sd0, 16'sd0, 1'b1, 16'd32768, 16'd0},
    '{RowTick, RegGainP, 32'd0, 16'sd256, 16'sd0, 1'b0, 16'd0, 16'd0},
    '{RowTick, RegGainP, 32'd0, 16'sd0, 16'sd256, 1'b0, 16'd0, 16'd0},
    '{RowTick, RegGainP, 32'd0, 16'sd1, 16'sd0, 1'b0, 16'd0, 16'd0},
    '{RowTick, RegGainP, 32'd0, 16'sd21845, -16'sd21846, 1'b0, 16'd0, 16'd0},
    '{RowTick, RegGainP, 32'd0, -16'sd21846, 16'sd21845, 1'b0, 16'd0, 16'd0},
    '{RowTick, RegGainP, 32'd0, SpeedTop, SpeedTop, 1'b0, 16'd0, 16'd0},
    '{RowTick, RegGainP, 32'd0, SpeedBottom, SpeedBottom, 1'b0, 16'd0, 16'd0},
    // all gains zero: no drive whatever the error
    '{RowGain, RegGainP, 32'd0, 16'sd0, 16'sd0, 1'b0, 16'd0, 16'd0},
    '{RowGain, RegGainI, 32'd0, 16'sd0, 16'sd0, 1'b0, 16'd0, 16'd0},
    '{RowGain, RegGainD, 32'd0, 16'sd0, 16'sd0, 1'b0, 16'd0, 16'd0},
    '{RowTick, RegGainP, 32'd0, SpeedTop, SpeedBottom, 1'b1, 16'd0, 16'd0},
    // write to the spare index must change nothing
    '{RowGain, RegSpare, 32'hffff_ffff, 16'sd0, 16'sd0, 1'b0, 16'd0, 16'd0},
    '{RowTick, RegGainP, 32'd0, SpeedBottom, SpeedTop, 1'b1, 16'd0, 16'd0},
    // tiny kp: rounding at half an output step
    '{RowGain, RegGainP, 32'd256, 16'sd0, 16'sd0, 1'b0, 16'd0, 16'd0},
    '{RowTick, RegGainP, 32'd0, 16'sd256, 16'sd0, 1'b1, 16'd1, 16'd0},
    '{RowTick, RegGainP, 32'd0, 16'sd255, 16'sd0, 1'b1, 16'd0, 16'd0},
    '{RowTick, RegGainP, 32'd0, -16'sd256, 16'sd0, 1'b1, 16'd0, 16'd1},
    // kp = 1.0: control value exactly at the clamp limits
    '{RowGain, RegGainP, 32'd16777216, 16'sd0, 16'sd0, 1'b0, 16'd0, 16'd0},
    '{RowTick, RegGainP, 32'd0, 16'sd256, 16'sd0, 1'b1, 16'd32768, 16'd0},
    '{RowTick, RegGainP, 32'd0, 16'sd0, 16'sd256, 1'b1, 16'd0, 16'd32768},
    '{RowTick, RegGainP, 32'd0, 16'sd0, 16'sd1, 1'b0, 16'd0, 16'd0},
    // all gains at maximum
    '{RowGain, RegGainP, 32'hffff_ffff, 16'sd0, 16'sd0, 1'b0, 16'd0, 16'd0},
    '{RowGain, RegGainI, 32'hffff_ffff, 16'sd0, 16'sd0, 1'b0, 16'd0, 16'd0},
    '{RowGain, RegGainD, 32'hffff_ffff, 16'sd0, 16'sd0, 1'b0, 16'd0, 16'd0},
    '{RowTick, RegGainP, 32'd0, 16'sd1, 16'sd0, 1'b0, 16'd0, 16'd0},
    '{RowTick, RegGainP, 32'd0, 16'sd0, 16'sd0, 1'b0, 16'd0, 16'd0},
    '{RowTick, RegGainP, 32'd0, -16'sd1, 16'sd0, 1'b0, 16'd0, 16'd0}
  };

  speed_pid_accel_brake uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One control tick: update error sum and last error, return both drives
  function automatic drive_t pid_drive(input logic signed [SpeedW-1:0] tgt,
                                       input logic signed [SpeedW-1:0] meas);
    int         err;
    longint     diff;
    longint     p_term;
    longint     d_term;
    longint     i_term;
    longint     total;
    longint     mag;
    logic [63:0] sum_abs;
    logic [79:0] i_prod;
    drive_t     res;
    err  = int'(tgt) - int'(meas);
    diff = longint'(err) - longint'(last_err);
    err_sum = err_sum + err;
    if (err_sum > SumTop) err_sum = SumTop;
    if (err_sum < SumBottom) err_sum = SumBottom;

    p_term = longint'(kp) * longint'(err);
    d_term = longint'(kd) * diff;
    // integral magnitude capped at 2^53 before the sum
    sum_abs = (err_sum < 0) ? -err_sum : err_sum;
    i_prod  = {16'd0, sum_abs} * {48'd0, ki};
    if (i_prod > ITermCap) i_prod = ITermCap;
    i_term = (err_sum < 0) ? -longint'(i_prod[63:0]) : longint'(i_prod[63:0]);
    last_err = err;

    total = p_term + d_term + i_term;
    if (total > FullScale) total = FullScale;
    if (total < -FullScale) total = -FullScale;
    mag = (total < 0) ? -total : total;
    res = '0;
    if (total >= 0) begin
      res.accel = DriveW'((mag + HalfLsb) >> 17);
    end else begin
      res.brake = DriveW'((mag + HalfLsb) >> 17);
    end
    return res;
  endfunction

  function automatic int rand_speed();
    return int'($signed(16'($urandom)));
  endfunction

  task automatic write_gain(input logic [CfgIdxW-1:0] idx, input logic [GainW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegGainP: kp = value;
      RegGainI: ki = value;
      RegGainD: kd = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Present one request, hold it until taken, then record the expected drives
  task automatic send_tick(input logic signed [SpeedW-1:0] tgt,
                           input logic signed [SpeedW-1:0] meas,
                           input logic known, input drive_t given);
    drive_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {meas, tgt};
    do @(posedge clk); while (!s_axis_tready);
    predicted = pid_drive(tgt, meas);
    drive_q.push_back(known ? given : predicted);
  endtask

  // Stop sending and let the pipeline empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (drive_q.size() != 0) @(posedge clk);
    repeat (PipeDepth + 2) @(posedge clk);
  endtask

  // Result checker and receiver stalls
  always @(posedge clk) begin
    drive_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (drive_q.size() == 0) begin
        $error("unexpected result: accel_drive %0d brake_drive %0d",
               m_axis_tdata[DriveW-1:0], m_axis_tdata[2*DriveW-1:DriveW]);
        fail_count++;
      end else begin
        want = drive_q.pop_front();
        if (m_axis_tdata[DriveW-1:0] !== want.accel) begin
          $error("accel_drive mismatch: expected %0d, got %0d",
                 want.accel, m_axis_tdata[DriveW-1:0]);
          fail_count++;
        end
        if (m_axis_tdata[2*DriveW-1:DriveW] !== want.brake) begin
          $error("brake_drive mismatch: expected %0d, got %0d",
                 want.brake, m_axis_tdata[2*DriveW-1:DriveW]);
          fail_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("speed_pid_accel_brake verification failed");
      $finish;
    end
  end

  initial begin
    int sent;
    int pick;
    int run_len;
    int anchor;
    int sign_dir;
    int tgt_i;
    int meas_i;
    logic [GainW-1:0] g_p;
    logic [GainW-1:0] g_i;
    logic [GainW-1:0] g_d;
    drive_t given;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part
    for (int r = 0; r < NumRows; r++) begin
      if (plan[r].kind == RowGain) begin
        drain();
        write_gain(plan[r].idx, plan[r].value);
      end else begin
        given.accel = plan[r].accel;
        given.brake = plan[r].brake;
        send_tick(plan[r].tgt, plan[r].meas, plan[r].known, given);
      end
    end

    // Random part: each segment gets its own gains; stall patterns change every two segments
    for (int seg = 0; seg < NumSegs; seg++) begin
      drain();
      send_idle_pct = (seg < 2) ? 28 : (seg < 4) ? 65 : 0;
      recv_idle_pct = (seg < 2) ? 65 : (seg < 4) ? 28 : 0;
      case (seg)
        0: begin
          g_p = GainPReset;
          g_i = GainIReset;
          g_d = GainDReset;
        end
        1: begin
          g_p = '1;
          g_i = '1;
          g_d = '1;
        end
        3: begin
          // integral only, so the capped I term shows through
          g_p = '0;
          g_i = '1;
          g_d = '0;
        end
        4: begin
          g_p = $urandom_range(33554431);
          g_i = $urandom_range(65535);
          g_d = $urandom_range(33554431);
        end
        default: begin
          g_p = $urandom >> $urandom_range(31);
          g_i = $urandom >> $urandom_range(31);
          g_d = $urandom >> $urandom_range(31);
        end
      endcase
      write_gain(RegGainP, g_p);
      write_gain(RegGainI, g_i);
      write_gain(RegGainD, g_d);
      write_gain(RegSpare, $urandom);

      sent = 0;
      while (sent < SegItems) begin
        pick     = $urandom_range(99);
        run_len  = (pick < 15) ? $urandom_range(60, 20) : $urandom_range(40, 1);
        anchor   = rand_speed();
        sign_dir = $urandom_range(1) ? 1 : -1;
        meas_i   = rand_speed();
        for (int k = 0; k < run_len && sent < SegItems; k++) begin
          if (pick < 15) begin
            // full-scale error held to wind up the sum
            tgt_i  = (sign_dir > 0) ? 32767 : -32768;
            meas_i = -tgt_i - 1;
          end else if (pick < 30) begin
            tgt_i  = rand_speed();
            meas_i = rand_speed();
          end else if (pick < 65) begin
            // steady offset of one sign
            tgt_i  = anchor;
            meas_i = anchor - sign_dir * int'($urandom_range(2048));
          end else begin
            // speed closing in on the target, with a little noise
            tgt_i  = anchor;
            meas_i = meas_i + (tgt_i - meas_i) / 4 + int'($urandom_range(64)) - 32;
          end
          if (meas_i > 32767) meas_i = 32767;
          if (meas_i < -32768) meas_i = -32768;
          send_tick(SpeedW'(tgt_i), SpeedW'(meas_i), 1'b0, '0);
          sent++;
        end
      end
    end

    drain();
    repeat (PipeDepth * 4) @(posedge clk);
    if (drive_q.size() != 0) begin
      $error("%0d expected results never arrived", drive_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("speed_pid_accel_brake verification clean");
    end else begin
      $display("speed_pid_accel_brake verification failed");
    end
    $finish;
  end

endmodule
